### rtl/sst_pkg.sv
// ============================================================================
// sst_pkg: shared types and constants for the sparse triplet transpose
// Index widths, configuration register indexes and the cell control word.
// ============================================================================
package sst_pkg;

    // Width of a one-based row or column index
    localparam int IDX_BITS = 7;

    // Largest matrix dimension accepted
    localparam int MAX_DIM = 64;

    // Reset value of both dimension registers
    localparam logic [IDX_BITS-1:0] DIM_RESET = 7'd64;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COLS = 1'b1;

    // Control word driven to every cell of the chain
    typedef struct packed {
        logic insert;   // place a new term in column order
        logic pop;      // shift the whole chain toward the head
    } sst_ctl_t;

endpackage

### rtl/sst_if.sv
// ============================================================================
// sst_if: word channels of the sparse triplet transpose
// Input term channel and output result channel, valid/ready handshake.
// ============================================================================
interface sst_term_if #(parameter int VALUE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic [6:0]                   term_row;
    logic [6:0]                   term_col;
    logic signed [VALUE_BITS-1:0] term_value;
    logic                         term_last;

    modport source (output valid, term_row, term_col, term_value, term_last,
                    input ready);
    modport sink   (input valid, term_row, term_col, term_value, term_last,
                    output ready);
endinterface

interface sst_result_if #(parameter int VALUE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic [6:0]                   out_row;
    logic [6:0]                   out_col;
    logic signed [VALUE_BITS-1:0] out_value;
    logic                         out_last;
    logic                         out_error;

    modport source (output valid, out_row, out_col, out_value, out_last, out_error,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, out_last, out_error,
                    output ready);
endinterface

### rtl/sparse_triplet_transpose_top.sv
// ============================================================================
// sparse_triplet_transpose_top: sparse matrix fast transpose on triplets
// Collects a set of triplets and returns them transposed in column order.
// ============================================================================
// Terms are accepted one per cycle and inserted into a chain of MAX_TERMS
// cells that keeps them sorted by source column, in arrival order within a
// column. The cycle after the term marked last, the set is returned one word
// per cycle while result.ready is high, from the head of the chain, with row
// and column swapped, and the term input is held off while a set is being
// returned. A term that lies outside num_rows/num_cols (or 64), or arrives
// with the chain full, is dropped and raises out_error on every word of its
// set. A set whose terms were all dropped returns nothing.
module sparse_triplet_transpose_top #(
    parameter int MAX_TERMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sst_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [sst_pkg::IDX_BITS-1:0]          cfg_data,
    sst_term_if.sink                              term,
    sst_result_if.source                          result
);
    import sst_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_TERMS + 1);

    typedef enum logic {
        LOAD,
        EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                drop_reg, drop_next;
    logic [IDX_BITS-1:0] num_rows_reg, num_cols_reg;

    logic     in_fire, out_fire, term_ok, full;
    sst_ctl_t ctl;

    logic                         c_keep  [MAX_TERMS];
    logic                         c_valid [MAX_TERMS];
    logic [IDX_BITS-1:0]          c_row   [MAX_TERMS];
    logic [IDX_BITS-1:0]          c_col   [MAX_TERMS];
    logic signed [VALUE_BITS-1:0] c_value [MAX_TERMS];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= DIM_RESET;
            num_cols_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                CFG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshakes and term admission
    assign term.ready = (state_reg == LOAD);
    assign in_fire    = term.valid && term.ready;
    assign out_fire   = result.valid && result.ready;
    assign full       = (count_reg == CNT_BITS'(MAX_TERMS));
    assign term_ok    = (term.term_row != '0) && (term.term_row <= num_rows_reg)
                     && (term.term_row <= IDX_BITS'(MAX_DIM))
                     && (term.term_col != '0) && (term.term_col <= num_cols_reg)
                     && (term.term_col <= IDX_BITS'(MAX_DIM)) && !full;

    assign ctl.insert = in_fire && term_ok;
    assign ctl.pop    = out_fire;

    // Set sequencing
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        case (state_reg)
            LOAD:
            begin
                if (in_fire)
                begin
                    count_next = count_reg + CNT_BITS'(term_ok);
                    drop_next  = drop_reg || !term_ok;
                    if (term.term_last)
                    begin
                        if (count_next != '0)
                            state_next = EMIT;
                        else
                            drop_next = 1'b0;
                    end
                end
            end
            EMIT:
            begin
                if (out_fire)
                begin
                    count_next = count_reg - CNT_BITS'(1);
                    if (count_reg == CNT_BITS'(1))
                    begin
                        state_next = LOAD;
                        drop_next  = 1'b0;
                    end
                end
            end
            default: state_next = LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    // Chain of sorted cells; cell 0 is the output head
    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        logic                         l_keep, l_valid, r_valid;
        logic [IDX_BITS-1:0]          l_row, l_col, r_row, r_col;
        logic signed [VALUE_BITS-1:0] l_value, r_value;

        if (i == 0)
        begin : g_head
            assign l_keep  = 1'b1;
            assign l_valid = 1'b0;
            assign l_row   = term.term_row;
            assign l_col   = term.term_col;
            assign l_value = term.term_value;
        end
        else
        begin : g_body
            assign l_keep  = c_keep[i-1];
            assign l_valid = c_valid[i-1];
            assign l_row   = c_row[i-1];
            assign l_col   = c_col[i-1];
            assign l_value = c_value[i-1];
        end

        if (i == MAX_TERMS - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_row   = '0;
            assign r_col   = '0;
            assign r_value = '0;
        end
        else
        begin : g_mid
            assign r_valid = c_valid[i+1];
            assign r_row   = c_row[i+1];
            assign r_col   = c_col[i+1];
            assign r_value = c_value[i+1];
        end

        sst_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_row     (term.term_row),
            .new_col     (term.term_col),
            .new_value   (term.term_value),
            .left_keep   (l_keep),
            .left_valid  (l_valid),
            .left_row    (l_row),
            .left_col    (l_col),
            .left_value  (l_value),
            .right_valid (r_valid),
            .right_row   (r_row),
            .right_col   (r_col),
            .right_value (r_value),
            .keep        (c_keep[i]),
            .valid       (c_valid[i]),
            .row         (c_row[i]),
            .col         (c_col[i]),
            .value       (c_value[i])
        );
    end

    // Result word straight from the chain head, indices swapped
    assign result.valid     = (state_reg == EMIT) && c_valid[0];
    assign result.out_row   = c_col[0];
    assign result.out_col   = c_row[0];
    assign result.out_value = c_value[0];
    assign result.out_last  = (count_reg == CNT_BITS'(1));
    assign result.out_error = drop_reg;

endmodule

### rtl/sst_cell.sv
// ============================================================================
// sst_cell: one slot of the column-ordered term chain
// Holds one stored term. The chain stays sorted by column, stable in arrival
// order; an insert shifts the tail right, a pop shifts everything left.
// ============================================================================
module sst_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sst_pkg::sst_ctl_t                     ctl,
    input  logic [sst_pkg::IDX_BITS-1:0]          new_row,
    input  logic [sst_pkg::IDX_BITS-1:0]          new_col,
    input  logic signed [VALUE_BITS-1:0]          new_value,
    input  logic                                  left_keep,
    input  logic                                  left_valid,
    input  logic [sst_pkg::IDX_BITS-1:0]          left_row,
    input  logic [sst_pkg::IDX_BITS-1:0]          left_col,
    input  logic signed [VALUE_BITS-1:0]          left_value,
    input  logic                                  right_valid,
    input  logic [sst_pkg::IDX_BITS-1:0]          right_row,
    input  logic [sst_pkg::IDX_BITS-1:0]          right_col,
    input  logic signed [VALUE_BITS-1:0]          right_value,
    output logic                                  keep,
    output logic                                  valid,
    output logic [sst_pkg::IDX_BITS-1:0]          row,
    output logic [sst_pkg::IDX_BITS-1:0]          col,
    output logic signed [VALUE_BITS-1:0]          value
);
    import sst_pkg::*;

    logic                         valid_reg, valid_next;
    logic [IDX_BITS-1:0]          row_reg, row_next;
    logic [IDX_BITS-1:0]          col_reg, col_next;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;

    // Entry stays put on insert when it sorts at or before the new term
    assign keep = valid_reg && (col_reg <= new_col);

    // Next contents: hold, take new term, take left neighbor, or take right
    always_comb
    begin
        valid_next = valid_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        value_next = value_reg;
        if (ctl.insert && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                row_next   = new_row;
                col_next   = new_col;
                value_next = new_value;
            end
            else
            begin
                valid_next = left_valid;
                row_next   = left_row;
                col_next   = left_col;
                value_next = left_value;
            end
        end
        else if (ctl.pop)
        begin
            valid_next = right_valid;
            row_next   = right_row;
            col_next   = right_col;
            value_next = right_value;
        end
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign row   = row_reg;
    assign col   = col_reg;
    assign value = value_reg;

endmodule

### rtl/sst_checker.sv
// ============================================================================
// sst_checker: port-level checks for the sparse triplet transpose
// Watches the term and result channels over time.
// ============================================================================
module sst_checker #(
    parameter int VALUE_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [6:0]            out_row,
    input logic [6:0]            out_col,
    input logic [VALUE_BITS-1:0] out_value,
    input logic                  out_last
);

    // No term taken while a set is being returned
    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("term input open while results pending");

    // Stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_row)
            && $stable(out_col) && $stable(out_value) && $stable(out_last)))
        else $error("result word changed while stalled");

    // Set ends after the last word
    a_end_of_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> !out_valid)
        else $error("result after last word");

    // Within a set, no gap and rows never decrease
    a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=>
            (out_valid && (out_row >= $past(out_row))))
        else $error("results out of column order");

    // Returned indices are one-based
    a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row != 7'd0 && out_col != 7'd0))
        else $error("zero index on result");

endmodule

bind sparse_triplet_transpose_top sst_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_sst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (term.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_row   (result.out_row),
    .out_col   (result.out_col),
    .out_value (result.out_value),
    .out_last  (result.out_last)
);

### dv/tb_sparse_triplet_transpose_top.sv
// ============================================================================
// tb_sparse_triplet_transpose_top: self-checking bench for the triplet transpose
// Sends sets of triplets with random valid/ready gaps, predicts each stable
// column-ordered transposed set, and checks every result word field by field
// across several dimension settings, including zero and oversized ones.
// ============================================================================
module tb_sparse_triplet_transpose_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TERMS  = 64;
    localparam int VALUE_BITS = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 200;
    localparam int SETTLE_CYCLES = 80;

    // One stored source triplet
    typedef struct {
        logic [6:0]                   row;
        logic [6:0]                   col;
        logic signed [VALUE_BITS-1:0] value;
    } term_word_t;

    // One expected transposed word
    typedef struct {
        logic [6:0]                   row;
        logic [6:0]                   col;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
        logic                         err;
    } transposed_word_t;

    // Predicts each set's transposed words and checks the block's output
    class transpose_scoreboard;
        logic [6:0]       dim_rows;
        logic [6:0]       dim_cols;
        term_word_t       set_terms[$];
        logic             set_dropped;
        transposed_word_t transposed_q[$];
        int               errors;
        int               terms_seen;
        int               sets_closed;
        int               words_checked;

        function new();
            dim_rows      = sst_pkg::DIM_RESET;
            dim_cols      = sst_pkg::DIM_RESET;
            set_dropped   = 1'b0;
            errors        = 0;
            terms_seen    = 0;
            sets_closed   = 0;
            words_checked = 0;
        endfunction

        function void write_dim(logic [sst_pkg::CFG_IDX_BITS-1:0] index, logic [6:0] data);
            if (index == sst_pkg::CFG_NUM_ROWS)
                dim_rows = data;
            else if (index == sst_pkg::CFG_NUM_COLS)
                dim_cols = data;
        endfunction

        function int outstanding();
            return transposed_q.size();
        endfunction

        // Store or drop one term; on the final term, queue the transposed set
        function void take_term(logic [6:0] row, logic [6:0] col,
                                logic signed [VALUE_BITS-1:0] value, logic last);
            int               lim_r;
            int               lim_c;
            int               k;
            term_word_t       t;
            transposed_word_t w;
            lim_r = (dim_rows > sst_pkg::MAX_DIM) ? sst_pkg::MAX_DIM : dim_rows;
            lim_c = (dim_cols > sst_pkg::MAX_DIM) ? sst_pkg::MAX_DIM : dim_cols;
            terms_seen++;
            if (row == 0 || row > lim_r || col == 0 || col > lim_c
                || set_terms.size() >= MAX_TERMS) begin
                set_dropped = 1'b1;
            end
            else begin
                t.row   = row;
                t.col   = col;
                t.value = value;
                set_terms.push_back(t);
            end
            if (!last)
                return;
            // column-major, arrival order kept within a column
            k = 0;
            for (int c = 1; c <= sst_pkg::MAX_DIM; c++) begin
                foreach (set_terms[i]) begin
                    if (set_terms[i].col == c) begin
                        w.row   = set_terms[i].col;
                        w.col   = set_terms[i].row;
                        w.value = set_terms[i].value;
                        k++;
                        w.last  = (k == set_terms.size());
                        w.err   = set_dropped;
                        transposed_q.push_back(w);
                    end
                end
            end
            sets_closed++;
            set_terms.delete();
            set_dropped = 1'b0;
        endfunction

        // Compare one result word with the oldest expectation
        function void check_word(logic [6:0] row, logic [6:0] col,
                                 logic signed [VALUE_BITS-1:0] value,
                                 logic last, logic err);
            transposed_word_t w;
            if (transposed_q.size() == 0) begin
                $error("result word with nothing expected: row %0d col %0d value %0d",
                       row, col, value);
                errors++;
                return;
            end
            w = transposed_q.pop_front();
            words_checked++;
            if (row !== w.row) begin
                $error("out_row: expected %0d, actual %0d", w.row, row);
                errors++;
            end
            if (col !== w.col) begin
                $error("out_col: expected %0d, actual %0d", w.col, col);
                errors++;
            end
            if (value !== w.value) begin
                $error("out_value: expected %0d, actual %0d", w.value, value);
                errors++;
            end
            if (last !== w.last) begin
                $error("out_last: expected %0b, actual %0b", w.last, last);
                errors++;
            end
            if (err !== w.err) begin
                $error("out_error: expected %0b, actual %0b", w.err, err);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [sst_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [sst_pkg::IDX_BITS-1:0]     cfg_data;

    sst_term_if   #(.VALUE_BITS(VALUE_BITS)) term_ch ();
    sst_result_if #(.VALUE_BITS(VALUE_BITS)) result_ch ();

    sparse_triplet_transpose_top #(
        .MAX_TERMS  (MAX_TERMS),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .term      (term_ch),
        .result    (result_ch)
    );

    transpose_scoreboard sb = new();

    int         send_idle_pct = 36;
    int         recv_idle_pct = 47;
    int         cycle_count   = 0;
    int         cfg_writes    = 0;
    logic [6:0] cur_rows      = sst_pkg::DIM_RESET;
    logic [6:0] cur_cols      = sst_pkg::DIM_RESET;

    // Dimension plan for the random phases; the last entry is drawn at random
    int rows_plan [8] = '{64, 1, 1, 64, 0, 64, 127, 0};
    int cols_plan [8] = '{64, 1, 64, 1, 64, 0, 127, 0};

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Accepted term and result words
    always @(posedge clk)
    begin
        if (rst_n && term_ch.valid && term_ch.ready)
            sb.take_term(term_ch.term_row, term_ch.term_col, term_ch.term_value,
                         term_ch.term_last);
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_word(result_ch.out_row, result_ch.out_col, result_ch.out_value,
                          result_ch.out_last, result_ch.out_error);
    end

    // Send one term word, with random gaps ahead of it
    task automatic send_term(input logic [6:0] row, input logic [6:0] col,
                             input logic signed [VALUE_BITS-1:0] value,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            term_ch.valid <= 1'b0;
            @(posedge clk);
        end
        term_ch.valid      <= 1'b1;
        term_ch.term_row   <= row;
        term_ch.term_col   <= col;
        term_ch.term_value <= value;
        term_ch.term_last  <= last;
        @(posedge clk);
        while (!term_ch.ready)
            @(posedge clk);
    endtask

    // Hold off the sender until every expected word is back, then let it settle
    task automatic drain();
        term_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller drops the write enable afterwards
    task automatic write_dim(input logic [sst_pkg::CFG_IDX_BITS-1:0] index,
                             input logic [6:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_dim(index, data);
        cfg_writes++;
        if (index == sst_pkg::CFG_NUM_ROWS)
            cur_rows = data;
        else
            cur_cols = data;
    endtask

    task automatic set_dims(input logic [6:0] rows, input logic [6:0] cols);
        write_dim(sst_pkg::CFG_NUM_ROWS, rows);
        write_dim(sst_pkg::CFG_NUM_COLS, cols);
        cfg_we <= 1'b0;
    endtask

    // Mostly in range for the current dimension, sometimes zero or past it
    function automatic logic [6:0] pick_index(logic [6:0] dim);
        int eff;
        eff = (dim > sst_pkg::MAX_DIM) ? sst_pkg::MAX_DIM : dim;
        if (eff == 0)
            return 7'($urandom_range(0, 127));
        if ($urandom_range(0, 9) != 0)
            return 7'($urandom_range(1, eff));
        if ($urandom_range(0, 1) == 0)
            return 7'd0;
        return 7'($urandom_range(eff + 1, 127));
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int count);
        for (int i = 0; i < count; i++)
            send_term(pick_index(cur_rows), pick_index(cur_cols), pick_value(),
                      i == count - 1);
    endtask

    function automatic int pick_set_size();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(60, 70);
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(11, 40);
        return $urandom_range(1, 10);
    endfunction

    // Stimulus
    initial
    begin
        int rand_items;
        int phase;
        int n;
        int guard;
        logic [6:0] r;
        logic [6:0] c;

        rand_items = 0;
        phase      = 0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = sst_pkg::CFG_NUM_ROWS;
        cfg_data           = '0;
        term_ch.valid      = 1'b0;
        term_ch.term_row   = '0;
        term_ch.term_col   = '0;
        term_ch.term_value = '0;
        term_ch.term_last  = 1'b0;
        result_ch.ready    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset dimensions, corners, stable order within a column
        send_term(7'd1, 7'd1, 32'sh8000_0000, 1'b1);
        send_term(7'd64, 7'd64, 32'sh7fff_ffff, 1'b0);
        send_term(7'd1, 7'd64, -32'sd1, 1'b0);
        send_term(7'd64, 7'd1, 32'sd0, 1'b1);
        // out-of-range rows and columns raise the error on the whole set
        send_term(7'd0, 7'd5, 32'sd11, 1'b0);
        send_term(7'd5, 7'd0, 32'sd12, 1'b0);
        send_term(7'd65, 7'd3, 32'sd13, 1'b0);
        send_term(7'd3, 7'd127, 32'sd14, 1'b0);
        send_term(7'd2, 7'd2, 32'sh5555_aaaa, 1'b1);
        // empty set: the only term is dropped, nothing comes back
        send_term(7'd0, 7'd0, 32'sd99, 1'b1);
        // dropped final term behind stored ones
        send_term(7'd3, 7'd4, 32'sh0f0f_0f0f, 1'b0);
        send_term(7'd4, 7'd3, 32'sh1234_5678, 1'b0);
        send_term(7'd127, 7'd127, 32'sd7, 1'b1);
        drain();

        // Smallest matrix
        set_dims(7'd1, 7'd1);
        send_term(7'd1, 7'd1, 32'sd42, 1'b0);
        send_term(7'd2, 7'd1, 32'sd43, 1'b0);
        send_term(7'd1, 7'd2, 32'sd44, 1'b1);
        drain();
        // Zero dimensions reject everything
        set_dims(7'd0, 7'd0);
        send_term(7'd1, 7'd1, 32'sd1, 1'b1);
        drain();
        // Oversized dimensions act as the largest
        set_dims(7'd127, 7'd127);
        send_term(7'd64, 7'd64, 32'sd5, 1'b0);
        send_term(7'd65, 7'd1, 32'sd6, 1'b1);
        drain();

        // Random phases, each under its own dimension setting
        while (rand_items < RANDOM_ITEMS)
        begin
            if (phase % 8 == 7)
            begin
                r = 7'($urandom_range(1, 64));
                c = 7'($urandom_range(1, 64));
            end
            else
            begin
                r = 7'(rows_plan[phase % 8]);
                c = 7'(cols_plan[phase % 8]);
            end
            set_dims(r, c);
            for (int s = 0; s < 3 && rand_items < RANDOM_ITEMS; s++)
            begin
                if (rand_items < RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 47;
                end
                else if (rand_items < 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 36;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // one oversized set early to overflow the store
                if (phase == 0 && s == 0)
                    n = 80;
                else if (r == 0 || c == 0)
                    n = $urandom_range(1, 4);
                else
                    n = pick_set_size();
                // keep the total near the planned item count
                if (n > RANDOM_ITEMS - rand_items)
                    n = RANDOM_ITEMS - rand_items;
                send_set(n);
                rand_items += n;
            end
            drain();
            phase++;
        end

        // Wind down
        term_ch.valid <= 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.outstanding() != 0)
        begin
            $error("%0d expected result words never arrived", sb.outstanding());
            sb.errors += sb.outstanding();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d terms in %0d sets over %0d dimension writes;",
                 sb.terms_seen, sb.sets_closed, cfg_writes);
        $display("%0d transposed words compared, %0d mismatches.",
                 sb.words_checked, sb.errors);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
